>>> design/sip_message_header_parser_defines.svh
// Assertion macros used by the SIP header parser module.
`ifndef SIP_MESSAGE_HEADER_PARSER_DEFINES_SVH
`define SIP_MESSAGE_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SIP_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sip_hp_pkg.sv
// Constants, prefix tables, record type and helpers for the SIP header parser.
package sip_hp_pkg;

    // sizing
    localparam int unsigned MAX_MESSAGE = 4096;
    localparam int unsigned MAX_CUSTOM  = 8;
    localparam int unsigned POS_W       = $clog2(MAX_MESSAGE + 1);
    localparam int unsigned CT_W        = $clog2(MAX_CUSTOM + 1);

    // fixed output field widths
    localparam int unsigned OFF_W  = 12;
    localparam int unsigned LEN_W  = 13;
    localparam int unsigned CODE_W = 3;

    // output queue
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int unsigned FCNT_W     = $clog2(FIFO_DEPTH + 1);

    // record kinds
    localparam logic REC_HEADER  = 1'b0;
    localparam logic REC_SUMMARY = 1'b1;

    // header kinds
    localparam logic [CODE_W-1:0] HK_CALL_ID = 3'd0;
    localparam logic [CODE_W-1:0] HK_FROM    = 3'd1;
    localparam logic [CODE_W-1:0] HK_TO      = 3'd2;
    localparam logic [CODE_W-1:0] HK_CSEQ    = 3'd3;
    localparam logic [CODE_W-1:0] HK_VIA     = 3'd4;
    localparam logic [CODE_W-1:0] HK_CUSTOM  = 3'd5;

    // method codes; a matched verb prefix k gives code k+1
    localparam logic [CODE_W-1:0] MC_UNKNOWN  = 3'd0;
    localparam logic [CODE_W-1:0] MC_INVITE   = 3'd1;
    localparam logic [CODE_W-1:0] MC_RESPONSE = 3'd6;

    // characters
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    // prefix table: six start-line verbs, five standard headers, custom marker
    localparam int unsigned PAT_NUM    = 12;
    localparam int unsigned NUM_VERBS  = 6;
    localparam int unsigned NUM_HDRS   = 5;
    localparam int unsigned HDR_BASE   = 6;
    localparam int unsigned PAT_CUSTOM = 11;
    localparam int unsigned CUSTOM_MIN = 2;
    localparam int unsigned VERB_MIN   = 3;

    localparam logic [79:0] PAT_TEXT [PAT_NUM] = '{
        "INVITE", "ACK", "CANCEL", "BYE", "OPTIONS", "SIP/2.0",
        "Call-ID: ", "From: ", "To: ", "CSeq: ", "Via: ", "X-"
    };
    localparam int unsigned PAT_LEN [PAT_NUM] = '{6, 3, 6, 3, 7, 7, 9, 6, 4, 6, 5, 2};

    // one result beat
    typedef struct packed {
        logic              record_kind;
        logic [CODE_W-1:0] header_kind;
        logic [CODE_W-1:0] custom_index;
        logic [OFF_W-1:0]  line_offset;
        logic [OFF_W-1:0]  name_length;
        logic [OFF_W-1:0]  value_offset;
        logic [LEN_W-1:0]  value_length;
        logic [CODE_W-1:0] method_code;
        logic              parse_ok;
        logic [OFF_W-1:0]  body_offset;
        logic [LEN_W-1:0]  body_length;
        logic              last_of_run;
    } t_rec;

    // character of prefix k at position off (text is right-aligned in its word)
    function automatic logic [7:0] pat_char(input int unsigned k, input logic [3:0] off);
        logic [6:0] sh;
        sh = '0;
        if (32'(off) < PAT_LEN[k]) sh = 7'(8 * (PAT_LEN[k] - 1 - 32'(off)));
        return PAT_TEXT[k][sh +: 8];
    endfunction

    // clamp a position to an offset field
    function automatic logic [OFF_W-1:0] sat_off(input logic [POS_W-1:0] x);
        logic [31:0] w;
        w = 32'(x);
        return (w > 32'((1 << OFF_W) - 1)) ? '1 : w[OFF_W-1:0];
    endfunction

    // clamp a position difference to a length field
    function automatic logic [LEN_W-1:0] sat_len(input logic [POS_W-1:0] x);
        logic [31:0] w;
        w = 32'(x);
        return (w > 32'((1 << LEN_W) - 1)) ? '1 : w[LEN_W-1:0];
    endfunction

    // clamp a slot number to the custom index field
    function automatic logic [CODE_W-1:0] sat_code(input logic [CT_W-1:0] x);
        logic [31:0] w;
        w = 32'(x);
        return (w > 32'((1 << CODE_W) - 1)) ? '1 : w[CODE_W-1:0];
    endfunction

endpackage

>>> design/sip_byte_if.sv
// Byte input channel of the SIP header parser.
interface sip_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

>>> design/sip_rec_if.sv
// Record output channel of the SIP header parser.
interface sip_rec_if;
    logic                          valid;
    logic                          ready;
    logic                          record_kind;
    logic [sip_hp_pkg::CODE_W-1:0] header_kind;
    logic [sip_hp_pkg::CODE_W-1:0] custom_index;
    logic [sip_hp_pkg::OFF_W-1:0]  line_offset;
    logic [sip_hp_pkg::OFF_W-1:0]  name_length;
    logic [sip_hp_pkg::OFF_W-1:0]  value_offset;
    logic [sip_hp_pkg::LEN_W-1:0]  value_length;
    logic [sip_hp_pkg::CODE_W-1:0] method_code;
    logic                          parse_ok;
    logic [sip_hp_pkg::OFF_W-1:0]  body_offset;
    logic [sip_hp_pkg::LEN_W-1:0]  body_length;
    logic                          last_of_run;

    modport source (
        output valid, output record_kind, output header_kind, output custom_index,
        output line_offset, output name_length, output value_offset, output value_length,
        output method_code, output parse_ok, output body_offset, output body_length,
        output last_of_run, input ready
    );
    modport sink (
        input valid, input record_kind, input header_kind, input custom_index,
        input line_offset, input name_length, input value_offset, input value_length,
        input method_code, input parse_ok, input body_offset, input body_length,
        input last_of_run, output ready
    );
endinterface

>>> design/sip_message_header_parser.sv
// SIP message header parser: byte-stream framing, header records and message summary.
//
// i_byte carries one datagram byte per beat; end_of_message marks the last byte.
// o_rec carries records: a header record for each recognised header line (emitted
// when its LF arrives) and a summary record on the final byte with method, parse
// status and body span. A byte causes at most two beats; last_of_run flags the last.
// A byte is parsed in the cycle it is accepted and its records are written to a
// four-entry output queue; o_rec shows the record held at the head of that queue.
// Throughput is one byte per cycle; the only limit is the queue, which takes a
// byte only while two entries are free. A byte that causes two records therefore
// fills two queue entries, which the receiver drains one record per handshake.
// When the receiver stalls, queued records hold and i_byte.ready drops once fewer
// than two entries remain free; nothing is lost or reordered.
// Synchronous active-low reset empties the queue and returns the parser to the
// start line of a fresh message; after a summary the parser resets itself.
`include "sip_message_header_parser_defines.svh"

module sip_message_header_parser (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sip_byte_if.sink   i_byte,
    sip_rec_if.source  o_rec
);
    import sip_hp_pkg::*;

    typedef enum logic [1:0] {PH_START, PH_HEADERS, PH_BODY} t_phase;

    // parser state
    t_phase             r_phase, n_phase;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [POS_W-1:0]   r_line_start, n_line_start;
    logic [PAT_NUM-1:0] r_hits, n_hits;
    logic               r_cr, n_cr;
    logic               r_colon, n_colon;
    logic [POS_W-1:0]   r_colon_pos, n_colon_pos;
    logic               r_blank, n_blank;
    logic [POS_W-1:0]   r_value_start, n_value_start;
    logic [CODE_W-1:0]  r_verb, n_verb;
    logic [CT_W-1:0]    r_ctaken, n_ctaken;
    logic [POS_W-1:0]   r_body_start, n_body_start;
    logic               r_failed, n_failed;

    // output queue
    t_rec               r_fifo [FIFO_DEPTH];
    logic [FPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [FCNT_W-1:0]  r_count;

    logic               w_acc, w_pop;
    logic               w_hdr_push, w_sum_push;
    t_rec               w_hdr_rec, w_sum_rec;
    logic [POS_W-1:0]   w_off, w_len, w_cr_pos;
    logic [7:0]         w_b;
    logic               w_hdr_found, w_ok;
    int unsigned        w_hdr_k;

    assign w_acc = i_byte.valid && i_byte.ready;
    assign w_pop = o_rec.valid && o_rec.ready;
    assign w_b   = i_byte.data_byte;

    // position arithmetic for the current byte
    assign w_off    = r_pos - r_line_start;
    assign w_cr_pos = r_pos - POS_W'(1);
    assign w_len    = w_cr_pos - r_line_start;

    // first standard header prefix that matched and has a value byte
    always_comb begin
        w_hdr_found = 1'b0;
        w_hdr_k     = 0;
        for (int k = NUM_HDRS - 1; k >= 0; k--) begin
            if (r_hits[HDR_BASE + k] && 32'(w_len) > PAT_LEN[HDR_BASE + k]) begin
                w_hdr_found = 1'b1;
                w_hdr_k     = k;
            end
        end
    end

    // per-byte parse step
    always_comb begin
        n_phase       = r_phase;
        n_pos         = r_pos;
        n_line_start  = r_line_start;
        n_hits        = r_hits;
        n_cr          = r_cr;
        n_colon       = r_colon;
        n_colon_pos   = r_colon_pos;
        n_blank       = r_blank;
        n_value_start = r_value_start;
        n_verb        = r_verb;
        n_ctaken      = r_ctaken;
        n_body_start  = r_body_start;
        n_failed      = r_failed;
        w_hdr_push    = 1'b0;
        w_hdr_rec     = '0;
        w_sum_push    = 1'b0;
        w_sum_rec     = '0;
        w_ok          = 1'b0;

        if (w_acc) begin
            if (32'(r_pos) >= MAX_MESSAGE) begin
                n_failed = 1'b1;
            end else begin
                n_pos = r_pos + POS_W'(1);
                if (!r_failed && r_phase != PH_BODY) begin
                    if (r_cr) begin
                        // byte after CR must be LF
                        n_cr = 1'b0;
                        if (w_b != CHAR_LF) begin
                            n_failed = 1'b1;
                        end else begin
                            if (r_phase == PH_START) begin
                                n_verb = MC_UNKNOWN;
                                if (32'(w_len) >= VERB_MIN) begin
                                    for (int k = NUM_VERBS - 1; k >= 0; k--) begin
                                        if (r_hits[k] && 32'(w_len) >= PAT_LEN[k])
                                            n_verb = CODE_W'(k + 1);
                                    end
                                end
                                n_phase = PH_HEADERS;
                            end else if (w_len == '0) begin
                                n_phase      = PH_BODY;
                                n_body_start = r_pos + POS_W'(1);
                            end else if (w_hdr_found) begin
                                w_hdr_push             = 1'b1;
                                w_hdr_rec.record_kind  = REC_HEADER;
                                w_hdr_rec.header_kind  = CODE_W'(w_hdr_k);
                                w_hdr_rec.line_offset  = sat_off(r_line_start);
                                w_hdr_rec.value_offset = sat_off(r_line_start
                                    + POS_W'(PAT_LEN[HDR_BASE + w_hdr_k]));
                                w_hdr_rec.value_length = sat_len(w_len
                                    - POS_W'(PAT_LEN[HDR_BASE + w_hdr_k]));
                            end else if (r_hits[PAT_CUSTOM] && 32'(w_len) > CUSTOM_MIN
                                         && 32'(r_ctaken) < MAX_CUSTOM && r_colon) begin
                                w_hdr_push             = 1'b1;
                                w_hdr_rec.record_kind  = REC_HEADER;
                                w_hdr_rec.header_kind  = HK_CUSTOM;
                                w_hdr_rec.custom_index = sat_code(r_ctaken);
                                w_hdr_rec.line_offset  = sat_off(r_line_start);
                                w_hdr_rec.name_length  = sat_off(r_colon_pos - r_line_start);
                                w_hdr_rec.value_offset = sat_off(r_value_start);
                                w_hdr_rec.value_length = sat_len(w_cr_pos - r_value_start);
                                n_ctaken               = r_ctaken + CT_W'(1);
                            end
                            // new line starts after the LF
                            n_line_start  = r_pos + POS_W'(1);
                            n_hits        = '1;
                            n_colon       = 1'b0;
                            n_colon_pos   = '0;
                            n_blank       = 1'b0;
                            n_value_start = '0;
                        end
                    end else if (w_b == CHAR_CR) begin
                        n_cr = 1'b1;
                    end else begin
                        // drop prefixes that this byte contradicts
                        for (int k = 0; k < PAT_NUM; k++) begin
                            if (32'(w_off) < PAT_LEN[k] && w_b != pat_char(k, w_off[3:0]))
                                n_hits[k] = 1'b0;
                        end
                        // colon and leading blanks of a custom value
                        if (!r_colon && w_b == CHAR_COLON) begin
                            n_colon       = 1'b1;
                            n_colon_pos   = r_pos;
                            n_value_start = r_pos + POS_W'(1);
                            n_blank       = 1'b1;
                        end else if (r_blank) begin
                            if (w_b == CHAR_SPACE || w_b == CHAR_TAB)
                                n_value_start = r_pos + POS_W'(1);
                            else
                                n_blank = 1'b0;
                        end
                    end
                end
            end

            // summary on the final byte, then back to a fresh message
            if (i_byte.end_of_message) begin
                w_ok = !n_failed && (n_phase == PH_BODY ||
                       (n_phase == PH_HEADERS && !n_cr && n_line_start == n_pos));
                w_sum_push              = 1'b1;
                w_sum_rec.record_kind   = REC_SUMMARY;
                w_sum_rec.method_code   = n_verb;
                w_sum_rec.parse_ok      = w_ok;
                w_sum_rec.last_of_run   = 1'b1;
                if (w_ok && n_phase == PH_BODY) begin
                    w_sum_rec.body_offset = sat_off(n_body_start);
                    w_sum_rec.body_length = sat_len(n_pos - n_body_start);
                end
                n_phase       = PH_START;
                n_pos         = '0;
                n_line_start  = '0;
                n_hits        = '1;
                n_cr          = 1'b0;
                n_colon       = 1'b0;
                n_colon_pos   = '0;
                n_blank       = 1'b0;
                n_value_start = '0;
                n_verb        = MC_UNKNOWN;
                n_ctaken      = '0;
                n_body_start  = '0;
                n_failed      = 1'b0;
            end
            w_hdr_rec.last_of_run = !w_sum_push;
        end
    end

    // state and output queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_START;
            r_pos         <= '0;
            r_line_start  <= '0;
            r_hits        <= '1;
            r_cr          <= 1'b0;
            r_colon       <= 1'b0;
            r_colon_pos   <= '0;
            r_blank       <= 1'b0;
            r_value_start <= '0;
            r_verb        <= MC_UNKNOWN;
            r_ctaken      <= '0;
            r_body_start  <= '0;
            r_failed      <= 1'b0;
            r_wr_ptr      <= '0;
            r_rd_ptr      <= '0;
            r_count       <= '0;
        end else begin
            r_phase       <= n_phase;
            r_pos         <= n_pos;
            r_line_start  <= n_line_start;
            r_hits        <= n_hits;
            r_cr          <= n_cr;
            r_colon       <= n_colon;
            r_colon_pos   <= n_colon_pos;
            r_blank       <= n_blank;
            r_value_start <= n_value_start;
            r_verb        <= n_verb;
            r_ctaken      <= n_ctaken;
            r_body_start  <= n_body_start;
            r_failed      <= n_failed;
            if (w_hdr_push)
                r_fifo[r_wr_ptr] <= w_hdr_rec;
            if (w_sum_push)
                r_fifo[r_wr_ptr + FPTR_W'(w_hdr_push)] <= w_sum_rec;
            r_wr_ptr <= r_wr_ptr + FPTR_W'(w_hdr_push) + FPTR_W'(w_sum_push);
            r_rd_ptr <= r_rd_ptr + FPTR_W'(w_pop);
            r_count  <= r_count + FCNT_W'(w_hdr_push) + FCNT_W'(w_sum_push)
                        - FCNT_W'(w_pop);
        end
    end

    // handshakes and head of queue
    assign i_byte.ready       = (32'(r_count) + 2) <= FIFO_DEPTH;
    assign o_rec.valid        = r_count != '0;
    assign o_rec.record_kind  = r_fifo[r_rd_ptr].record_kind;
    assign o_rec.header_kind  = r_fifo[r_rd_ptr].header_kind;
    assign o_rec.custom_index = r_fifo[r_rd_ptr].custom_index;
    assign o_rec.line_offset  = r_fifo[r_rd_ptr].line_offset;
    assign o_rec.name_length  = r_fifo[r_rd_ptr].name_length;
    assign o_rec.value_offset = r_fifo[r_rd_ptr].value_offset;
    assign o_rec.value_length = r_fifo[r_rd_ptr].value_length;
    assign o_rec.method_code  = r_fifo[r_rd_ptr].method_code;
    assign o_rec.parse_ok     = r_fifo[r_rd_ptr].parse_ok;
    assign o_rec.body_offset  = r_fifo[r_rd_ptr].body_offset;
    assign o_rec.body_length  = r_fifo[r_rd_ptr].body_length;
    assign o_rec.last_of_run  = r_fifo[r_rd_ptr].last_of_run;

    // checks
    `SIP_ASSERT(a_fifo_bound, i_clk, i_rst_n, 1'b1, 32'(r_count) <= FIFO_DEPTH, "queue overflow")
    `SIP_ASSERT(a_pos_bound, i_clk, i_rst_n, 1'b1, 32'(r_pos) <= MAX_MESSAGE, "position overrun")
    `SIP_ASSERT(a_no_hdr_body, i_clk, i_rst_n, w_acc && r_phase == PH_BODY, !w_hdr_push, "header in body")
    `SIP_ASSERT_NEXT(a_eom_clear, i_clk, i_rst_n, w_acc && i_byte.end_of_message, r_pos == '0 && r_phase == PH_START && !r_failed, "no reset after summary")

endmodule
